>>> hdl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg : shared types and constants of the affine orbit canonicaliser
// field constants, controller state type and control/status structs
// ----------------------------------------------------------------------------
package aoc_pkg;

  localparam int WORD_W  = 256;
  localparam int POS_W   = 8;
  localparam int CNT_W   = 16;
  localparam int DEG_W   = 4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PAIR,
    S_LOGD,
    S_INV,
    S_IMAGE,
    S_FLUSH,
    S_DONE
  } aoc_state_t;

  typedef struct packed {
    logic load;       // latch input word and degree
    logic scan_step;  // examine one position
    logic pair_setup; // read both elements of the current pair
    logic pair_log;   // look up the log of their sum
    logic pair_inv;   // look up the map coefficient
    logic img_step;   // map one element
    logic pair_done;  // compare image with best
    logic next_pair;  // advance pair indices
    logic finish;     // present result
  } aoc_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic img_last;
    logic pairs_last;
    logic pair_same;
    logic pipe_busy;
    logic bad;
    logic few;
  } aoc_stat_t;

  // field multiply, bit-serial over at most eight steps of narrow values
  function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in,
                                        input logic [3:0] m, input logic [8:0] poly);
    logic [8:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [8:0] top;
    a = {1'b0, a_in};
    b = b_in;
    r = '0;
    top = 9'd1 << m;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(m)) begin
        if (b[0]) r = r ^ a[7:0];
        b = b >> 1;
        a = a << 1;
        if ((a & top) != 9'd0) a = a ^ poly;
      end
    end
    return r & 8'(top - 9'd1);
  endfunction

endpackage

>>> hdl/affine_orbit_canonicalizer.sv
// ----------------------------------------------------------------------------
// affine_orbit_canonicaliser : smallest affine image of a support word
// controller plus datapath; one request at a time
// ----------------------------------------------------------------------------
// usage
//   in_tdata carries the 256-bit support word, out_tdata the smallest image,
//   the stabiliser count and a status code
//   cfg_we/cfg_wdata set the field degree (3, 5, 7 or 8, other values mean 8)
//   sequence: the request is accepted and all 256 positions are scanned; then
//   each ordered pair of distinct elements gets set-up, the mapping of every
//   element and a pipe flush, each same-index pair is skipped, and the
//   result is handed over last
//   a bad or too light word returns straight after the scan
//   one request is in flight; in_tready is high only when idle, so the next
//   request can be taken in the cycle after the result is handed over
//   the result register holds its value while out_tready is low, and a
//   finished request waits in the controller until that register is free
//   reset clears the controller and sets the degree to 8
// ----------------------------------------------------------------------------
module affine_orbit_canonicalizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // word_limb0, word_limb1, word_limb2, word_limb3
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [279:0] out_tdata,  // canon_limb0..3, stabilizer_count, status, pad
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);
  import aoc_pkg::*;

  logic [3:0]   degree_r;
  aoc_cmd_t     cmd;
  aoc_stat_t    stat;
  logic         busy;
  logic [255:0] best_word;
  logic [15:0]  best_count;
  logic [1:0]   res_status;
  logic         oval_r;
  logic [279:0] odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) degree_r <= 4'd8;
    else if (cfg_we) degree_r <= cfg_wdata;
  end

  assign in_tready = !busy;

  aoc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(in_tvalid),
    .out_free(!oval_r || out_tready), .stat(stat), .cmd(cmd), .busy(busy)
  );

  aoc_dp u_dp (
    .clk(clk), .word_in(in_tdata), .degree(degree_r), .cmd(cmd), .stat(stat),
    .best_word(best_word), .best_count(best_count), .res_status(res_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) oval_r <= 1'b0;
    else if (cmd.finish) oval_r <= 1'b1;
    else if (out_tready) oval_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) odata_r <= {6'd0, res_status, best_count, best_word};
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !busy) else $error("ready while busy");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!oval_r || out_tready)) else $error("result overwritten");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[273:272] != 2'd3) else $error("bad status");
`endif

endmodule

>>> hdl/aoc_ctrl.sv
// ----------------------------------------------------------------------------
// aoc_ctrl : sequencing controller
// steps through scan, pair set-up and per-element mapping
// ----------------------------------------------------------------------------
module aoc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              out_free,
  input  aoc_pkg::aoc_stat_t stat,
  output aoc_pkg::aoc_cmd_t  cmd,
  output logic              busy
);
  import aoc_pkg::*;

  aoc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN:  if (stat.scan_last) begin
        if (stat.bad || stat.few) state_nxt = S_DONE;
        else state_nxt = S_PAIR;
      end
      S_PAIR:  if (stat.pair_same) begin
        if (stat.pairs_last) state_nxt = S_DONE;
      end else state_nxt = S_LOGD;
      S_LOGD:  state_nxt = S_INV;
      S_INV:   state_nxt = S_IMAGE;
      S_IMAGE: if (stat.img_last) state_nxt = S_FLUSH;
      S_FLUSH: if (!stat.pipe_busy) state_nxt = S_PAIR;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE:  begin busy = 1'b0; cmd.load = start; end
      S_SCAN:  cmd.scan_step = 1'b1;
      S_PAIR:  begin
        cmd.pair_setup = !stat.pair_same;
        cmd.next_pair  = stat.pair_same;
      end
      S_LOGD:  cmd.pair_log = 1'b1;
      S_INV:   cmd.pair_inv = 1'b1;
      S_IMAGE: cmd.img_step = 1'b1;
      S_FLUSH: begin
        cmd.pair_done = !stat.pipe_busy;
        cmd.next_pair = !stat.pipe_busy;
      end
      S_DONE:  cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/aoc_dp.sv
// ----------------------------------------------------------------------------
// aoc_dp : datapath
// element list, field tables, image build and smallest-image tracking
// ----------------------------------------------------------------------------
module aoc_dp (
  input  logic                   clk,
  input  logic [255:0]           word_in,
  input  logic [3:0]             degree,
  input  aoc_pkg::aoc_cmd_t      cmd,
  output aoc_pkg::aoc_stat_t     stat,
  output logic [255:0]           best_word,
  output logic [15:0]            best_count,
  output logic [1:0]             res_status
);
  import aoc_pkg::*;

  logic [255:0] word_r;
  logic [3:0]   m_r;
  logic [8:0]   poly_r;
  logic [7:0]   n_r;
  logic [8:0]   pos_r;          // scan position
  logic [8:0]   k_r;            // element count
  logic [7:0]   elem_mem [256]; // element list
  logic [7:0]   ix_r, iy_r, iz_r;
  logic [7:0]   x_r, y_r, z_r;
  logic [7:0]   lgd_r, a_r, lgt_r;
  logic         zero_r;
  logic         v1_r, v2_r;     // image pipe stage valids
  logic [255:0] img_r, best_r;
  logic [15:0]  cnt_r;
  logic         have_r, bad_r;

  // exp and log tables, filled during the scan
  logic [7:0] expt [256];
  logic [7:0] logt [256];
  logic [7:0] ev_r;
  logic [7:0] inv_e;
  logic [7:0] t_val;
  logic [7:0] e_addr;
  logic [7:0] l_addr;

  always_comb begin
    stat.scan_last  = (pos_r == 9'd255);
    stat.bad        = bad_r || (word_r[pos_r[7:0]] && (pos_r >= (9'd1 << m_r)));
    stat.few        = (k_r + {8'd0, (word_r[pos_r[7:0]] && !stat.bad)}) < 9'd2;
    stat.img_last   = ({1'b0, iz_r} == k_r - 9'd1);
    stat.pairs_last = ({1'b0, ix_r} == k_r - 9'd1) && ({1'b0, iy_r} == k_r - 9'd1);
    stat.pair_same  = (ix_r == iy_r);
    stat.pipe_busy  = v1_r || v2_r;
  end

  // a*z + a*x folded into a*(z + x)
  assign t_val  = gf_mul(a_r, z_r ^ x_r, m_r, poly_r);
  assign inv_e  = (lgd_r == 8'd0) ? 8'd0 : n_r - lgd_r;
  assign e_addr = cmd.img_step ? iz_r : ix_r;
  assign l_addr = v1_r ? t_val : (x_r ^ y_r);

  always_ff @(posedge clk) begin
    v1_r <= cmd.img_step;
    v2_r <= v1_r;
    if (cmd.load) begin
      word_r <= word_in;
      unique case (degree)
        4'd3: begin m_r <= 4'd3; poly_r <= 9'h00B; n_r <= 8'd7; end
        4'd5: begin m_r <= 4'd5; poly_r <= 9'h025; n_r <= 8'd31; end
        4'd7: begin m_r <= 4'd7; poly_r <= 9'h083; n_r <= 8'd127; end
        default: begin m_r <= 4'd8; poly_r <= 9'h14D; n_r <= 8'd255; end
      endcase
      pos_r <= '0; k_r <= '0; bad_r <= 1'b0; have_r <= 1'b0;
      ix_r <= '0; iy_r <= '0; iz_r <= '0; cnt_r <= '0; best_r <= '0;
      ev_r <= 8'd1;
    end
    if (cmd.scan_step) begin
      expt[pos_r[7:0]] <= ev_r;
      if ({1'b0, pos_r[7:0]} < {1'b0, n_r}) logt[ev_r] <= pos_r[7:0];
      ev_r <= gf_mul(ev_r, 8'd2, m_r, poly_r);
      pos_r <= pos_r + 9'd1;
      if (word_r[pos_r[7:0]]) begin
        if (pos_r >= (9'd1 << m_r)) bad_r <= 1'b1;
        else begin
          elem_mem[k_r[7:0]] <= (pos_r[7:0] == n_r) ? 8'd0 : ev_r;
          k_r <= k_r + 9'd1;
        end
      end
    end
    if (cmd.pair_setup) begin
      x_r <= elem_mem[e_addr];
      y_r <= elem_mem[iy_r];
      img_r <= '0;
      iz_r <= '0;
    end
    if (cmd.pair_log) lgd_r <= logt[l_addr];
    if (cmd.pair_inv) a_r <= expt[inv_e];
    // stage one: fetch the element
    if (cmd.img_step) begin
      z_r <= elem_mem[e_addr];
      iz_r <= iz_r + 8'd1;
    end
    // stage two: log of the mapped value
    if (v1_r) begin
      lgt_r  <= logt[l_addr];
      zero_r <= (t_val == 8'd0);
    end
    // stage three: mark the image position
    if (v2_r) img_r[zero_r ? n_r : lgt_r] <= 1'b1;
    if (cmd.pair_done) begin
      if (!have_r || img_r < best_r) begin
        best_r <= img_r; cnt_r <= 16'd1; have_r <= 1'b1;
      end else if (img_r == best_r) cnt_r <= cnt_r + 16'd1;
    end
    if (cmd.next_pair) begin
      if ({1'b0, iy_r} == k_r - 9'd1) begin
        iy_r <= '0; ix_r <= ix_r + 8'd1;
      end else iy_r <= iy_r + 8'd1;
    end
  end

  assign best_word  = (bad_r || k_r < 9'd2) ? '0 : best_r;
  assign best_count = (bad_r || k_r < 9'd2) ? '0 : cnt_r;
  assign res_status = bad_r ? ST_RANGE : ((k_r < 9'd2) ? ST_FEW : ST_OK);

endmodule
